// ===== hdl/spi3w_pkg.sv =====
// ----------------------------------------------------------------------------
// spi3w_pkg
// Shared types and constants of the three-wire SPI register master.
// ----------------------------------------------------------------------------
`default_nettype none

package spi3w_pkg;

  // Widths of the stream payloads; the tdata widths are padded to whole bytes.
  localparam int unsigned InTdataWidth  = 24;
  localparam int unsigned InTuserWidth  = 2;
  localparam int unsigned OutTdataWidth = 16;

  // Serial byte format.
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned BitsWidth = 4;

  // Command byte flags.
  localparam int unsigned AutoIncBit = 6;
  localparam int unsigned MsbBit     = 7;

  // Bit timing register.
  localparam logic [7:0] HalfPeriodReset = 8'd10;

  // Request kinds carried in tuser.
  typedef enum logic [1:0] {
    OpWrite    = 2'd0,
    OpRead     = 2'd1,
    OpReadNext = 2'd2,
    OpEnd      = 2'd3
  } op_e;

  // Transfer sequencer, one-hot.
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StCmdW  = 6'b000010,
    StWData = 6'b000100,
    StCmdR  = 6'b001000,
    StRData = 6'b010000,
    StHeld  = 6'b100000
  } stage_e;

endpackage

`default_nettype wire

// ===== hdl/three_wire_spi_register_master.sv =====
// ----------------------------------------------------------------------------
// three_wire_spi_register_master
// Register master for a three-wire SPI device (clock mode 3, MSB first).
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the s_axis channel is one tick of the bit timing
//   generator. tuser carries the request kind (write, read, read next, end
//   burst); tdata carries the request flag, the command and write bytes and
//   the sampled level of the shared data pin. Each input transaction yields
//   exactly one m_axis transaction holding the pin levels and status after
//   that tick, plus the received byte on the tick a read completes.
//   A valid output appears in the cycle after input acceptance; one item is
//   accepted every cycle unless the output stalls, as each tick update is one
//   combinational pass from the state registers into the output register.
//   A single output register separates the two sides: while it holds an
//   untaken result and m_axis_tready is low, s_axis_tready drops and the tick
//   state stays frozen.
//   Reset releases select and the pin, idles the clock high and loads the
//   half period register with ten ticks. The cfg channel is always ready; a
//   write applies from the next accepted tick, so a change during a transfer
//   takes effect at the next phase check.
// ----------------------------------------------------------------------------
`default_nettype none

module three_wire_spi_register_master #(
  parameter logic [7:0] HalfPeriodInit = spi3w_pkg::HalfPeriodReset
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Bit timing register write.
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [7:0]                          cfg_data_i,
  // Tick input.
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // [0] request_valid, [8:1] command_byte, [16:9] write_byte,
  // [17] data_pin_in, [23:18] zero
  input  wire logic [spi3w_pkg::InTdataWidth-1:0]  s_axis_tdata,
  // [1:0] op
  input  wire logic [spi3w_pkg::InTuserWidth-1:0]  s_axis_tuser,
  // Tick result.
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [0] serial_clock, [1] data_pin_out, [2] data_pin_drive, [3] select_active,
  // [4] busy_res, [12:5] read_byte, [13] read_valid, [15:14] zero
  output      logic [spi3w_pkg::OutTdataWidth-1:0] m_axis_tdata
);

  // Unpacked input fields.
  logic                 req;
  spi3w_pkg::op_e       op;
  logic [7:0]           cmd;
  logic [7:0]           wbyte;
  logic                 pin;
  logic                 in_fire;

  assign req     = s_axis_tdata[0];
  assign cmd     = s_axis_tdata[8:1];
  assign wbyte   = s_axis_tdata[16:9];
  assign pin     = s_axis_tdata[17];
  assign op      = spi3w_pkg::op_e'(s_axis_tuser);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Tick state.
  logic [7:0]                    half_q;
  logic [7:0]                    tick_q, tick_d;
  logic                          phase_q, phase_d;
  logic [spi3w_pkg::BitsWidth-1:0] bits_q, bits_d;
  logic [7:0]                    tx_q, tx_d;
  logic [7:0]                    rx_q, rx_d;
  logic [7:0]                    pend_q, pend_d;
  spi3w_pkg::stage_e             stage_q, stage_d;
  logic                          keep_q, keep_d;
  logic                          sel_q, sel_d;
  logic                          drv_q, drv_d;
  logic                          done;

  // Output register.
  logic                                out_valid_q;
  logic [spi3w_pkg::OutTdataWidth-1:0] out_data_q, out_data_d;

  logic       busy;
  logic       busy_next;
  logic [7:0] half_eff;
  logic [8:0] tick_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign busy      = (stage_q != spi3w_pkg::StIdle) && (stage_q != spi3w_pkg::StHeld);
  assign busy_next = (stage_d != spi3w_pkg::StIdle) && (stage_d != spi3w_pkg::StHeld);
  assign half_eff  = (half_q == 8'd0) ? 8'd1 : half_q;
  assign tick_inc  = {1'b0, tick_q} + 9'd1;

  // One tick of the sequencer.
  always_comb begin
    tick_d  = tick_q;
    phase_d = phase_q;
    bits_d  = bits_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    pend_d  = pend_q;
    stage_d = stage_q;
    keep_d  = keep_q;
    sel_d   = sel_q;
    drv_d   = drv_q;
    done    = 1'b0;
    if (busy) begin
      if (tick_inc < {1'b0, half_eff}) begin
        tick_d = tick_inc[7:0];
      end else begin
        tick_d = 8'd0;
        if (!phase_q) begin
          // Sample the pin just before the rising clock edge.
          if (stage_q == spi3w_pkg::StRData) begin
            rx_d = {rx_q[6:0], pin};
          end
          phase_d = 1'b1;
        end else begin
          bits_d = bits_q - spi3w_pkg::BitsWidth'(1);
          tx_d   = {tx_q[6:0], 1'b0};
          if (bits_d != '0) begin
            phase_d = 1'b0;
          end else begin
            // End of a byte: move on to the next part of the sequence.
            unique case (stage_q)
              spi3w_pkg::StCmdW: begin
                tx_d    = pend_q;
                stage_d = spi3w_pkg::StWData;
                bits_d  = spi3w_pkg::BitsWidth'(spi3w_pkg::ByteBits);
                phase_d = 1'b0;
              end
              spi3w_pkg::StCmdR: begin
                drv_d   = 1'b0;
                stage_d = spi3w_pkg::StRData;
                bits_d  = spi3w_pkg::BitsWidth'(spi3w_pkg::ByteBits);
                phase_d = 1'b0;
              end
              spi3w_pkg::StWData: begin
                sel_d   = 1'b0;
                drv_d   = 1'b0;
                stage_d = spi3w_pkg::StIdle;
              end
              spi3w_pkg::StRData: begin
                done = 1'b1;
                if (keep_q) begin
                  stage_d = spi3w_pkg::StHeld;
                end else begin
                  sel_d   = 1'b0;
                  stage_d = spi3w_pkg::StIdle;
                end
              end
              default: begin
                stage_d = spi3w_pkg::StIdle;
              end
            endcase
          end
        end
      end
    end else if (req) begin
      unique case (op) inside
        spi3w_pkg::OpWrite, spi3w_pkg::OpRead: begin
          tx_d    = cmd;
          sel_d   = 1'b1;
          drv_d   = 1'b1;
          bits_d  = spi3w_pkg::BitsWidth'(spi3w_pkg::ByteBits);
          phase_d = 1'b0;
          tick_d  = 8'd0;
          if (op == spi3w_pkg::OpWrite) begin
            pend_d  = wbyte;
            keep_d  = 1'b0;
            stage_d = spi3w_pkg::StCmdW;
          end else begin
            keep_d  = cmd[spi3w_pkg::AutoIncBit];
            stage_d = spi3w_pkg::StCmdR;
          end
        end
        spi3w_pkg::OpReadNext: begin
          if (stage_q == spi3w_pkg::StHeld) begin
            drv_d   = 1'b0;
            keep_d  = 1'b1;
            stage_d = spi3w_pkg::StRData;
            bits_d  = spi3w_pkg::BitsWidth'(spi3w_pkg::ByteBits);
            phase_d = 1'b0;
            tick_d  = 8'd0;
          end
        end
        default: begin
          sel_d   = 1'b0;
          drv_d   = 1'b0;
          keep_d  = 1'b0;
          stage_d = spi3w_pkg::StIdle;
        end
      endcase
    end
  end

  // Result word for this tick.
  always_comb begin
    out_data_d        = '0;
    out_data_d[0]     = phase_d;
    out_data_d[1]     = drv_d && tx_d[spi3w_pkg::MsbBit];
    out_data_d[2]     = drv_d;
    out_data_d[3]     = sel_d;
    out_data_d[4]     = busy_next;
    out_data_d[12:5]  = done ? rx_d : 8'd0;
    out_data_d[13]    = done;
  end

  // Bit timing register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfPeriodInit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      half_q <= cfg_data_i;
    end
  end

  // Sequencer state, advanced once per accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= 8'd0;
      phase_q <= 1'b1;
      bits_q  <= '0;
      tx_q    <= 8'd0;
      rx_q    <= 8'd0;
      pend_q  <= 8'd0;
      stage_q <= spi3w_pkg::StIdle;
      keep_q  <= 1'b0;
      sel_q   <= 1'b0;
      drv_q   <= 1'b0;
    end else if (in_fire) begin
      tick_q  <= tick_d;
      phase_q <= phase_d;
      bits_q  <= bits_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      pend_q  <= pend_d;
      stage_q <= stage_d;
      keep_q  <= keep_d;
      sel_q   <= sel_d;
      drv_q   <= drv_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  // The master only drives the pin while the device is selected.
  assert property (@(posedge clk_i) disable iff (!rst_ni) drv_q |-> sel_q)
    else $error("data pin driven without select");

  // A shifting transfer always holds select.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> sel_q)
    else $error("transfer in progress without select");

  // The bit counter never exceeds one byte and is nonzero while shifting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (bits_q != '0) && (bits_q <= spi3w_pkg::BitsWidth'(spi3w_pkg::ByteBits)))
    else $error("bit counter out of range");

  // State only moves on an accepted tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(stage_q) && $stable(tick_q))
    else $error("sequencer advanced without an input tick");

endmodule

`default_nettype wire

// ===== tb/spi3w_tick_checker.sv =====
// ----------------------------------------------------------------------------
// spi3w_tick_checker
// Watches the tick, result and bit timing channels of the three-wire SPI
// register master. It predicts the pin levels and the received byte for every
// accepted tick and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module spi3w_tick_checker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  input  wire logic                                cfg_ready_i,
  input  wire logic [7:0]                          cfg_data_i,
  input  wire logic                                s_tvalid_i,
  input  wire logic                                s_tready_i,
  // [0] request_valid, [8:1] command_byte, [16:9] write_byte,
  // [17] data_pin_in, [23:18] zero
  input  wire logic [spi3w_pkg::InTdataWidth-1:0]  s_tdata_i,
  // [1:0] op
  input  wire logic [spi3w_pkg::InTuserWidth-1:0]  s_tuser_i,
  input  wire logic                                m_tvalid_i,
  input  wire logic                                m_tready_i,
  // [0] serial_clock, [1] data_pin_out, [2] data_pin_drive, [3] select_active,
  // [4] busy_res, [12:5] read_byte, [13] read_valid, [15:14] zero
  input  wire logic [spi3w_pkg::OutTdataWidth-1:0] m_tdata_i,
  output      int                                  mismatch_count_o,
  output      int                                  pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Pin levels and status after one tick, laid out as in the result tdata.
  typedef struct packed {
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy;
    logic       select;
    logic       drive;
    logic       pin_out;
    logic       sclk;
  } pins_t;

  // Predicted master state.
  logic [7:0]        half_period;
  logic [7:0]        tick_div;
  logic              phase_high;
  logic [3:0]        bits_left;
  logic [7:0]        tx_shift;
  logic [7:0]        rx_shift;
  logic [7:0]        pend_byte;
  spi3w_pkg::stage_e stage;
  logic              keep_sel;
  logic              sel;
  logic              drive;

  pins_t expected_pins[$];

  function automatic logic is_shifting();
    return (stage != spi3w_pkg::StIdle) && (stage != spi3w_pkg::StHeld);
  endfunction

  // Every byte opens with a fresh low clock phase.
  function automatic void start_byte(spi3w_pkg::stage_e next);
    stage      = next;
    bits_left  = 4'(spi3w_pkg::ByteBits);
    phase_high = 1'b0;
    tick_div   = '0;
  endfunction

  // One tick of a running transfer. Returns 1 when a read byte completes.
  function automatic logic advance_clock(logic pin);
    logic [7:0] span;
    span = (half_period == 8'd0) ? 8'd1 : half_period;
    if ({1'b0, tick_div} + 9'd1 < {1'b0, span}) begin
      tick_div = tick_div + 8'd1;
      return 1'b0;
    end
    tick_div = '0;
    // The pin is sampled as the low phase ends, just before the rising clock.
    if (!phase_high) begin
      if (stage == spi3w_pkg::StRData) rx_shift = {rx_shift[6:0], pin};
      phase_high = 1'b1;
      return 1'b0;
    end
    bits_left = bits_left - 4'd1;
    tx_shift  = tx_shift << 1;
    if (bits_left != 4'd0) begin
      phase_high = 1'b0;
      return 1'b0;
    end
    // End of a byte: move on to the next stage of the sequence.
    case (stage)
      spi3w_pkg::StCmdW: begin
        tx_shift = pend_byte;
        start_byte(spi3w_pkg::StWData);
      end
      spi3w_pkg::StCmdR: begin
        drive = 1'b0;
        start_byte(spi3w_pkg::StRData);
      end
      spi3w_pkg::StWData: begin
        sel   = 1'b0;
        drive = 1'b0;
        stage = spi3w_pkg::StIdle;
      end
      spi3w_pkg::StRData: begin
        if (keep_sel) begin
          stage = spi3w_pkg::StHeld;
        end else begin
          sel   = 1'b0;
          stage = spi3w_pkg::StIdle;
        end
        return 1'b1;
      end
      default: stage = spi3w_pkg::StIdle;
    endcase
    return 1'b0;
  endfunction

  // Applies one tick and returns the pin levels that follow it.
  function automatic pins_t predict_tick(logic req, spi3w_pkg::op_e op, logic [7:0] cmd,
                                         logic [7:0] wb, logic pin);
    pins_t levels;
    logic  done;
    done = 1'b0;
    if (is_shifting()) begin
      done = advance_clock(pin);
    end else if (req) begin
      case (op) inside
        spi3w_pkg::OpWrite, spi3w_pkg::OpRead: begin
          tx_shift = cmd;
          sel      = 1'b1;
          drive    = 1'b1;
          if (op == spi3w_pkg::OpWrite) begin
            pend_byte = wb;
            keep_sel  = 1'b0;
            start_byte(spi3w_pkg::StCmdW);
          end else begin
            keep_sel = cmd[spi3w_pkg::AutoIncBit];
            start_byte(spi3w_pkg::StCmdR);
          end
        end
        spi3w_pkg::OpReadNext: begin
          // Only meaningful while select is held after an auto-increment read.
          if (stage == spi3w_pkg::StHeld) begin
            drive    = 1'b0;
            keep_sel = 1'b1;
            start_byte(spi3w_pkg::StRData);
          end
        end
        default: begin
          sel      = 1'b0;
          drive    = 1'b0;
          keep_sel = 1'b0;
          stage    = spi3w_pkg::StIdle;
        end
      endcase
    end
    levels.sclk       = phase_high;
    levels.pin_out    = drive & tx_shift[spi3w_pkg::MsbBit];
    levels.drive      = drive;
    levels.select     = sel;
    levels.busy       = is_shifting();
    levels.read_byte  = done ? rx_shift : 8'h00;
    levels.read_valid = done;
    return levels;
  endfunction

  // Results are checked before the tick of the same edge is predicted, since
  // a result never leaves in the cycle its tick is taken. A register write
  // applies from the following tick on.
  always @(posedge clk_i or negedge rst_ni) begin : track_ticks
    pins_t got;
    pins_t want;
    if (!rst_ni) begin
      half_period = spi3w_pkg::HalfPeriodReset;
      tick_div    = '0;
      phase_high  = 1'b1;
      bits_left   = '0;
      tx_shift    = '0;
      rx_shift    = '0;
      pend_byte   = '0;
      stage       = spi3w_pkg::StIdle;
      keep_sel    = 1'b0;
      sel         = 1'b0;
      drive       = 1'b0;
      expected_pins.delete();
      mismatch_count_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = pins_t'(m_tdata_i[13:0]);
        if (expected_pins.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: result with no tick outstanding: %h", $realtime, m_tdata_i);
          mismatch_count_o++;
        end else begin
          want = expected_pins.pop_front();
          if (got !== want) begin
            if (mismatch_count_o < 10)
              $display("%0t: result mismatch: expected %b %b %b %b %b %h %b, got %b %b %b %b %b %h %b",
                       $realtime, want.sclk, want.pin_out, want.drive, want.select,
                       want.busy, want.read_byte, want.read_valid, got.sclk,
                       got.pin_out, got.drive, got.select, got.busy, got.read_byte,
                       got.read_valid);
            mismatch_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_pins.push_back(predict_tick(s_tdata_i[0], spi3w_pkg::op_e'(s_tuser_i),
                                             s_tdata_i[8:1], s_tdata_i[16:9],
                                             s_tdata_i[17]));
      if (cfg_valid_i && cfg_ready_i) half_period = cfg_data_i;
    end
    pending_count_o = expected_pins.size();
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and requests into the three-wire SPI register master: a short
// directed sequence over the request kinds and corner cases, then random
// phases at several bit timings, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 1000;

  logic                                cfg_valid     = 1'b0;
  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                cfg_ready;
  logic [7:0]                          cfg_data      = '0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [spi3w_pkg::InTdataWidth-1:0]  s_axis_tdata  = '0;
  logic [spi3w_pkg::InTuserWidth-1:0]  s_axis_tuser  = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [spi3w_pkg::OutTdataWidth-1:0] m_axis_tdata;

  logic calm = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   mismatch_count;
  int   pending_count;

  three_wire_spi_register_master uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  spi3w_tick_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // The result side stalls in random bursts unless the run is in a calm stretch.
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Ends the run when no transaction has happened on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one tick and returns at the edge where it is taken. Valid stays
  // high afterwards so that ticks can follow back to back.
  task automatic send_tick(logic req, spi3w_pkg::op_e op, logic [7:0] cmd, logic [7:0] wb,
                           logic pin);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, pin, wb, cmd, req};
    s_axis_tuser  <= op;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic request(spi3w_pkg::op_e op, logic [7:0] cmd, logic [7:0] wb);
    send_tick(1'b1, op, cmd, wb, 1'($urandom_range(0, 1)));
  endtask

  // Ticks without a request; the pin is fixed, or random when pin_mode < 0.
  task automatic idle_ticks(int count, int pin_mode);
    for (int i = 0; i < count; i++)
      send_tick(1'b0, spi3w_pkg::op_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)),
                (pin_mode < 0) ? 1'($urandom_range(0, 1)) : 1'(pin_mode));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // The half period is only rewritten once every result has come back.
  task automatic set_half_period(logic [7:0] ticks);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Random ticks biased toward auto-increment reads and read-next bursts.
  task automatic random_phase(int count);
    int             pick;
    spi3w_pkg::op_e op;
    logic [7:0]     cmd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      op   = (pick < 2) ? spi3w_pkg::OpWrite :
             (pick < 4) ? spi3w_pkg::OpRead :
             (pick < 8) ? spi3w_pkg::OpReadNext : spi3w_pkg::OpEnd;
      cmd  = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 4) < 3) cmd[spi3w_pkg::AutoIncBit] = 1'b1;
      send_tick(1'($urandom_range(0, 1)), op, cmd, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [7:0] phase_ticks [8];
    phase_ticks = '{8'd1, 8'd3, 8'd0, 8'd2, 8'd5, 8'd1, 8'd4, 8'd2};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the fastest bit timing.
    set_half_period(8'd1);
    request(spi3w_pkg::OpEnd, 8'h00, 8'h00);
    request(spi3w_pkg::OpReadNext, 8'h00, 8'h00);
    request(spi3w_pkg::OpWrite, 8'h00, 8'hFF);
    request(spi3w_pkg::OpRead, 8'hFF, 8'h00);
    idle_ticks(34, -1);
    request(spi3w_pkg::OpWrite, 8'hFF, 8'h00);
    idle_ticks(34, -1);
    request(spi3w_pkg::OpRead, 8'h80, 8'h00);
    idle_ticks(34, 1);
    request(spi3w_pkg::OpRead, 8'h3F, 8'hFF);
    idle_ticks(34, 0);
    request(spi3w_pkg::OpReadNext, 8'h00, 8'h00);
    request(spi3w_pkg::OpRead, 8'hC0, 8'h00);
    idle_ticks(34, -1);
    request(spi3w_pkg::OpReadNext, 8'h00, 8'h00);
    idle_ticks(18, -1);
    request(spi3w_pkg::OpReadNext, 8'h00, 8'h00);
    idle_ticks(18, 1);
    // A new command while select is still held.
    request(spi3w_pkg::OpWrite, 8'h7F, 8'hA5);
    idle_ticks(34, -1);
    request(spi3w_pkg::OpRead, 8'h40, 8'h00);
    idle_ticks(34, -1);
    request(spi3w_pkg::OpEnd, 8'h00, 8'h00);
    request(spi3w_pkg::OpEnd, 8'h00, 8'h00);

    // A zero half period runs like one tick per phase.
    set_half_period(8'd0);
    request(spi3w_pkg::OpWrite, 8'h5A, 8'hC3);
    idle_ticks(34, -1);

    // Slowest timing, then a faster one written while the read is under way.
    set_half_period(8'd255);
    request(spi3w_pkg::OpRead, 8'hC0, 8'h00);
    idle_ticks(300, -1);
    set_half_period(8'd2);
    idle_ticks(70, -1);
    request(spi3w_pkg::OpReadNext, 8'h00, 8'h00);
    idle_ticks(36, -1);
    request(spi3w_pkg::OpEnd, 8'h00, 8'h00);

    // Random phases; one in the middle and the last without any stalls.
    foreach (phase_ticks[p]) begin
      set_half_period(phase_ticks[p]);
      calm <= (p == 5) || (p == 7);
      random_phase(28);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
